/* sv/cq_pkg.sv */
// ----------------------------------------------------------------------------
// cq_pkg
// Shared constants and codes for the circular queue: field widths, the
// default depth, operation and status codes and the controller states.
// ----------------------------------------------------------------------------
package cq_pkg;

    localparam int DEPTH_DEFAULT = 8;
    localparam int OPCODE_W      = 2;
    localparam int DATA_W        = 32;
    localparam int STATUS_W      = 2;
    localparam int OCC_W         = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_DELETE  = 2'd1,
        OP_DISPLAY = 2'd2
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } state_t;

endpackage

/* sv/cq_cmd_if.sv */
// ----------------------------------------------------------------------------
// cq_cmd_if
// Command channel of the circular queue: an operation code and a word.
// ----------------------------------------------------------------------------
interface cq_cmd_if;

    logic                                valid;
    logic                                ready;
    logic [cq_pkg::OPCODE_W-1:0]         opcode;
    logic signed [cq_pkg::DATA_W-1:0]    value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);

endinterface

/* sv/cq_rsp_if.sv */
// ----------------------------------------------------------------------------
// cq_rsp_if
// Result channel of the circular queue: a word, a status code, an end
// marker and the occupancy after the operation.
// ----------------------------------------------------------------------------
interface cq_rsp_if;

    logic                                valid;
    logic                                ready;
    logic signed [cq_pkg::DATA_W-1:0]    data;
    logic [cq_pkg::STATUS_W-1:0]         status;
    logic                                last;
    logic [cq_pkg::OCC_W-1:0]            occupancy;

    modport source (output valid, output data, output status, output last,
                    output occupancy, input ready);
    modport sink   (input valid, input data, input status, input last,
                    input occupancy, output ready);

endinterface

/* sv/cq_ram.sv */
// ----------------------------------------------------------------------------
// cq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// The read data holds its value until the next read.
// ----------------------------------------------------------------------------
module cq_ram #(
    parameter int WIDTH  = cq_pkg::DATA_W,
    parameter int DEPTH  = cq_pkg::DEPTH_DEFAULT,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/circular_queue.sv */
// ----------------------------------------------------------------------------
// circular_queue
// Ring queue of signed 32-bit words kept in a synchronous RAM. Insert stores
// at the tail, delete returns the head, display streams every stored word
// from head to tail.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Word contents                        Handshake
//  -------  ---  -----------------------------------  ---------------
//  cmd      in   opcode, value                         valid / ready
//  rsp      out  data, status, last, occupancy         valid / ready
//
// An insert, and any operation that fails (overflow, underflow, display of
// an empty queue), may be followed at once by the next command. A delete or
// a display reads the entry RAM, which has a registered read and a single
// read port, and emits its words from the read state.
// Reset clears the indices, the count and the output valid flag; the RAM
// contents are not cleared and no clearing pass is run.
// A stalled result channel holds the result in the output register; the
// next command is still taken while the previous result waits, and for an
// insert or a failing operation the controller parks in a hold state
// with the new status until the output register frees up.
//
module circular_queue #(
    parameter int DEPTH = cq_pkg::DEPTH_DEFAULT
) (
    input  logic     clk,
    input  logic     rst_n,
    cq_cmd_if.sink   cmd,
    cq_rsp_if.source rsp
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    // Controller state and queue bookkeeping.
    cq_pkg::state_t  state_reg, state_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    // Next RAM address and number of words still to emit while streaming.
    logic [IW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   left_reg, left_next;
    // Status of an immediate result that could not enter the output register.
    cq_pkg::status_t hold_status_reg, hold_status_next;

    // Output register.
    logic                          ov_reg, ov_next;
    logic signed [cq_pkg::DATA_W-1:0] od_reg, od_next;
    cq_pkg::status_t               os_reg, os_next;
    logic                          ol_reg, ol_next;
    logic [cq_pkg::OCC_W-1:0]      oo_reg, oo_next;

    // RAM port signals.
    logic                          wr_en;
    logic                          rd_en;
    logic [IW-1:0]                 rd_addr;
    logic [cq_pkg::DATA_W-1:0]     rd_data;

    logic            accept;
    logic            slot_free;
    logic            full;
    logic            empty;
    cq_pkg::status_t imm_status;
    logic            imm_result;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx);
        logic [IW-1:0] res;
        if (idx == IW'(DEPTH - 1))
        begin
            res = '0;
        end
        else
        begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    cq_ram #(
        .WIDTH (cq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (cmd.value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmd.ready = (state_reg == cq_pkg::S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    // The output register can take a word if it is empty or is being taken.
    assign slot_free = !ov_reg || rsp.ready;
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    assign rsp.valid     = ov_reg;
    assign rsp.data      = od_reg;
    assign rsp.status    = os_reg;
    assign rsp.last      = ol_reg;
    assign rsp.occupancy = oo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= cq_pkg::S_IDLE;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            ptr_reg         <= '0;
            left_reg        <= '0;
            hold_status_reg <= cq_pkg::ST_OK;
            ov_reg          <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            ptr_reg         <= ptr_next;
            left_reg        <= left_next;
            hold_status_reg <= hold_status_next;
            ov_reg          <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        os_reg <= os_next;
        ol_reg <= ol_next;
        oo_reg <= oo_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        ptr_next         = ptr_reg;
        left_next        = left_reg;
        hold_status_next = hold_status_reg;
        ov_next          = rsp.ready ? 1'b0 : ov_reg;
        od_next          = od_reg;
        os_next          = os_reg;
        ol_next          = ol_reg;
        oo_next          = oo_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        rd_addr          = head_reg;
        imm_status       = cq_pkg::ST_OK;
        imm_result       = 1'b0;

        unique case (state_reg)
            cq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cq_pkg::opcode_t'(cmd.opcode))
                        cq_pkg::OP_INSERT:
                        begin
                            imm_result = 1'b1;
                            if (full)
                            begin
                                imm_status = cq_pkg::ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                tail_next  = wrap_inc(tail_reg);
                                count_next = CW'(count_reg + 1'b1);
                            end
                        end
                        cq_pkg::OP_DELETE:
                        begin
                            if (empty)
                            begin
                                imm_result = 1'b1;
                                imm_status = cq_pkg::ST_UNDERFLOW;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                head_next  = wrap_inc(head_reg);
                                count_next = CW'(count_reg - 1'b1);
                                left_next  = CW'(1);
                                state_next = cq_pkg::S_READ;
                            end
                        end
                        cq_pkg::OP_DISPLAY:
                        begin
                            if (empty)
                            begin
                                imm_result = 1'b1;
                                imm_status = cq_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                ptr_next   = wrap_inc(head_reg);
                                left_next  = count_reg;
                                state_next = cq_pkg::S_READ;
                            end
                        end
                        default:
                        begin
                            // Unused code: no result and no change.
                        end
                    endcase

                    if (imm_result)
                    begin
                        if (slot_free)
                        begin
                            ov_next = 1'b1;
                            od_next = '0;
                            os_next = imm_status;
                            ol_next = 1'b1;
                            oo_next = cq_pkg::OCC_W'(count_next);
                        end
                        else
                        begin
                            hold_status_next = imm_status;
                            state_next       = cq_pkg::S_HOLD;
                        end
                    end
                end
            end

            cq_pkg::S_READ:
            begin
                // The RAM read data holds until the next read, so a stall
                // simply waits here.
                if (slot_free)
                begin
                    ov_next = 1'b1;
                    od_next = rd_data;
                    os_next = cq_pkg::ST_OK;
                    ol_next = (left_reg == CW'(1));
                    oo_next = cq_pkg::OCC_W'(count_reg);
                    if (left_reg == CW'(1))
                    begin
                        state_next = cq_pkg::S_IDLE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = ptr_reg;
                        ptr_next  = wrap_inc(ptr_reg);
                        left_next = CW'(left_reg - 1'b1);
                    end
                end
            end

            cq_pkg::S_HOLD:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    od_next    = '0;
                    os_next    = hold_status_reg;
                    ol_next    = 1'b1;
                    oo_next    = cq_pkg::OCC_W'(count_reg);
                    state_next = cq_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = cq_pkg::S_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    // The count never runs past the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");

    // An empty or a full queue has its indices on the same entry.
    a_ring_align: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0 || count_reg == CW'(DEPTH)) |-> (tail_reg == head_reg))
        else $error("head and tail disagree with the count");

    // While reading, at least one word is still owed.
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cq_pkg::S_READ) |-> (left_reg != '0))
        else $error("read state with no words left");

    // Streaming leaves the queue bookkeeping untouched.
    a_read_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cq_pkg::S_READ) |=> ($stable(count_reg) && $stable(tail_reg)))
        else $error("queue state changed during a read");
`endif

endmodule
